// File: sv/cbe_pkg.sv
// Shared types, constants and lookup functions for the Codabar bar encoder.
`default_nettype none
package cbe_pkg;

  // Configuration port geometry and register indexes
  localparam int CFG_DATA_W = 4;
  localparam int CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] REG_NARROW_MODULES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDE_MODULES   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_ENABLE   = 2'd2;

  localparam logic [3:0] NARROW_RESET = 4'd1;
  localparam logic [3:0] WIDE_RESET   = 4'd3;

  localparam int NUM_SYMBOLS = 20;

  // Width patterns per symbol value, read MSB first, 1 = wide
  localparam logic [7:0] PATTERN_OF_VALUE [NUM_SYMBOLS] = '{
    8'h06, 8'h0c, 8'h12, 8'hc0, 8'h24, 8'h84, 8'h42, 8'h48, 8'h60, 8'h90,
    8'h18, 8'h30, 8'h8a, 8'ha2, 8'ha8, 8'h2a, 8'h34, 8'h52, 8'h16, 8'h1c
  };

  // Element position of the inter-character gap within a symbol
  localparam logic [2:0] GAP_POS  = 3'd7;
  localparam logic [2:0] STOP_END = 3'd6;

  typedef struct packed {
    logic [3:0] narrow_modules;
    logic [3:0] wide_modules;
    logic       check_enable;
  } cfg_t;

  // One accepted character, reduced to what the sequencer has to emit
  typedef struct packed {
    logic       err;      // single error result, no elements
    logic       mend;     // request carried the stop character
    logic       two;      // check symbol first, then the stop symbol
    logic [7:0] pat0;     // pattern of the first symbol
    logic [7:0] pat1;     // pattern of the stop symbol when two is set
  } job_t;

  typedef struct packed {
    logic       valid;
    logic [4:0] value;
  } sym_val_t;

  // Map an ASCII character onto its symbol value
  function automatic sym_val_t symbol_value(input logic [7:0] c);
    sym_val_t r;
    r.valid = 1'b1;
    r.value = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.value = 5'(c - 8'h30);
    end else begin
      case (c)
        8'h2d:        r.value = 5'd10;  // '-'
        8'h24:        r.value = 5'd11;  // '$'
        8'h3a:        r.value = 5'd12;  // ':'
        8'h2f:        r.value = 5'd13;  // '/'
        8'h2e:        r.value = 5'd14;  // '.'
        8'h2b:        r.value = 5'd15;  // '+'
        8'h41, 8'h54: r.value = 5'd16;  // 'A', 'T'
        8'h42, 8'h4e: r.value = 5'd17;  // 'B', 'N'
        8'h43, 8'h2a: r.value = 5'd18;  // 'C', '*'
        8'h44, 8'h45: r.value = 5'd19;  // 'D', 'E'
        default:      r.valid = 1'b0;
      endcase
    end
    return r;
  endfunction

  // Pattern byte of a symbol value
  function automatic logic [7:0] pattern_of(input logic [4:0] v);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < NUM_SYMBOLS; i++) begin
      if (v == 5'(i)) p = PATTERN_OF_VALUE[i];
    end
    return p;
  endfunction

endpackage
`default_nettype wire

// File: sv/cbe_symbol_if.sv
// Input channel: one message character per request.
`default_nettype none
interface cbe_symbol_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol_char;
  logic       last_symbol;

  modport source (output valid, output symbol_char, output last_symbol, input ready);
  modport sink   (input valid, input symbol_char, input last_symbol, output ready);
endinterface
`default_nettype wire

// File: sv/cbe_element_if.sv
// Output channel: one bar or space element per request.
`default_nettype none
interface cbe_element_if;
  logic       valid;
  logic       ready;
  logic [3:0] element_width;
  logic       is_bar;
  logic       is_wide;
  logic       message_end;
  logic       run_end;
  logic       bad_char;

  modport source (output valid, output element_width, output is_bar, output is_wide,
                  output message_end, output run_end, output bad_char, input ready);
  modport sink   (input valid, input element_width, input is_bar, input is_wide,
                  input message_end, input run_end, input bad_char, output ready);
endinterface
`default_nettype wire

// File: sv/cbe_front.sv
// Character decode, running check sum and error latch.
`default_nettype none
module cbe_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         accept,
  input  wire logic [7:0]   symbol_char,
  input  wire logic         last_symbol,
  input  wire cbe_pkg::cfg_t cfg,
  output cbe_pkg::job_t     job
);

  logic [3:0] check_sum;
  logic       error_latched;

  cbe_pkg::sym_val_t sv;
  logic       bad;
  logic [3:0] sum_next;
  logic [3:0] check_value;

  // Decode and form the job for the sequencer
  always_comb begin
    sv          = cbe_pkg::symbol_value(symbol_char);
    bad         = error_latched || !sv.valid;
    sum_next    = check_sum + sv.value[3:0];
    check_value = 4'(4'd0 - sum_next);
    job.err     = bad;
    job.mend    = last_symbol;
    job.two     = !bad && last_symbol && cfg.check_enable;
    job.pat0    = job.two ? cbe_pkg::pattern_of({1'b0, check_value})
                          : cbe_pkg::pattern_of(sv.value);
    job.pat1    = cbe_pkg::pattern_of(sv.value);
  end

  // Update message state on each accepted character
  always_ff @(posedge clk) begin
    if (rst) begin
      check_sum     <= 4'd0;
      error_latched <= 1'b0;
    end else if (accept) begin
      if (last_symbol) begin
        check_sum     <= 4'd0;
        error_latched <= 1'b0;
      end else if (bad) begin
        error_latched <= 1'b1;
      end else begin
        check_sum <= sum_next;
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/cbe_sequencer.sv
// Job register, element counter and output register.
`default_nettype none
module cbe_sequencer (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cbe_pkg::cfg_t cfg,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire cbe_pkg::job_t job_in,
  cbe_element_if.source      elements
);

  logic          job_valid;
  cbe_pkg::job_t job;
  logic          seg;
  logic [2:0]    pos;

  logic       out_load;
  logic       seg_last;
  logic       seg_len7;
  logic       pos_end;
  logic       run_end_c;
  logic       mend_c;
  logic       wide_c;
  logic [7:0] pat;
  logic       take;

  // Current element of the job
  always_comb begin
    pat       = seg ? job.pat1 : job.pat0;
    seg_last  = seg || !job.two;
    seg_len7  = seg_last && job.mend;
    pos_end   = seg_len7 ? (pos == cbe_pkg::STOP_END) : (pos == cbe_pkg::GAP_POS);
    run_end_c = job.err || (seg_last && pos_end);
    mend_c    = job.err ? job.mend : (seg_len7 && pos_end);
    wide_c    = !job.err && (pos != cbe_pkg::GAP_POS) && pat[~pos];
    out_load  = job_valid && (!elements.valid || elements.ready);
    take      = !job_valid || (out_load && run_end_c);
    in_ready  = take;
  end

  // Hold the job and walk its elements
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      seg       <= 1'b0;
      pos       <= 3'd0;
    end else if (take) begin
      job_valid <= in_valid;
      seg       <= 1'b0;
      pos       <= 3'd0;
    end else if (out_load) begin
      if (pos_end) begin
        seg <= 1'b1;
        pos <= 3'd0;
      end else begin
        pos <= pos + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_valid) begin
      job <= job_in;
    end
  end

  // Output register: drop on handshake, load the next element
  always_ff @(posedge clk) begin
    if (rst) begin
      elements.valid <= 1'b0;
    end else if (out_load) begin
      elements.valid <= 1'b1;
    end else if (elements.ready) begin
      elements.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      elements.element_width <= job.err ? 4'd0
                              : (wide_c ? cfg.wide_modules : cfg.narrow_modules);
      elements.is_bar        <= !job.err && !pos[0];
      elements.is_wide       <= wide_c;
      elements.message_end   <= mend_c;
      elements.run_end       <= run_end_c;
      elements.bad_char      <= job.err;
    end
  end

endmodule
`default_nettype wire

// File: sv/codabar_bar_encoder.sv
// Top level of the Codabar bar encoder with optional modulo-16 check character.
//
//   channel   dir  handshake      payload
//   symbols   in   valid/ready    symbol_char[7:0], last_symbol
//   elements  out  valid/ready    element_width[3:0], is_bar, is_wide,
//                                 message_end, run_end, bad_char
//   cfg       in   cfg_we         cfg_index[1:0], cfg_data[3:0]
//
// A character yields 8 elements, a stop character 7, a stop with the check
// character 15 and an error 1, one element per cycle while the output takes
// them. The element counter in the sequencer walks them; the next character
// is taken in the cycle its predecessor's last element enters the output
// register. Output stalls hold the element counter. Reset (rst, synchronous)
// clears the check sum, error latch, valid flags and restores the registers.
`default_nettype none
module codabar_bar_encoder (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [cbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cbe_pkg::CFG_DATA_W-1:0] cfg_data,
  cbe_symbol_if.sink                          symbols,
  cbe_element_if.source                       elements
);

  cbe_pkg::cfg_t cfg;
  cbe_pkg::job_t job;
  logic          accept;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.narrow_modules <= cbe_pkg::NARROW_RESET;
      cfg.wide_modules   <= cbe_pkg::WIDE_RESET;
      cfg.check_enable   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        cbe_pkg::REG_NARROW_MODULES: cfg.narrow_modules <= cfg_data;
        cbe_pkg::REG_WIDE_MODULES:   cfg.wide_modules   <= cfg_data;
        cbe_pkg::REG_CHECK_ENABLE:   cfg.check_enable   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign accept = symbols.valid && symbols.ready;

  cbe_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .symbol_char (symbols.symbol_char),
    .last_symbol (symbols.last_symbol),
    .cfg         (cfg),
    .job         (job)
  );

  cbe_sequencer u_sequencer (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (symbols.valid),
    .in_ready (symbols.ready),
    .job_in   (job),
    .elements (elements)
  );

endmodule
`default_nettype wire
